FILE: hw/rtl/utc_pkg.sv
// Shared types, constants and the month-length function for the seconds-to-calendar block.
`default_nettype none

package utc_pkg;

  // Divisors for splitting seconds into days and time of day
  localparam logic [17:0] SECS_PER_DAY  = 18'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;

  // Scaled reciprocals; each quotient is exact over its whole input range
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // ceil(2^35 / 675), seconds >> 7 in
  localparam logic [17:0] HOUR_RECIP = 18'd149131;    // ceil(2^29 / 3600)
  localparam logic [12:0] MIN_RECIP  = 13'd4370;      // ceil(2^18 / 60)

  // Epoch year and its residues for the leap-year counters
  localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
  localparam logic [1:0]  EPOCH_MOD4   = 2'd2;
  localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
  localparam logic [8:0]  EPOCH_MOD400 = 9'd370;
  localparam logic [8:0]  DAYS_IN_YEAR = 9'd365;

  // Loop bound
  localparam logic [3:0] LAST_MONTH = 4'd12;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAY_MUL,
    ST_DAY_FIX,
    ST_HOUR_MUL,
    ST_HOUR_FIX,
    ST_MIN_MUL,
    ST_MIN_FIX,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DAY_MUL,
    OP_DAY_FIX,
    OP_HOUR_MUL,
    OP_HOUR_FIX,
    OP_MIN_MUL,
    OP_MIN_FIX,
    OP_YEAR,
    OP_MONTH,
    OP_PUBLISH
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
    logic out_free;
  } dp_status_t;

  // Length of a month, February lengthened in leap years
  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    begin
      case (mon)
        4'd2:                      len = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
        default:                   len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/utc_dp.sv
// Datapath: reciprocal-multiply dividers, year and month counters, and the output register.
`default_nettype none

module utc_dp
  import utc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  output dp_status_t       status,
  input  wire logic [31:0] utc_seconds,
  input  wire logic        out_stall,
  output logic             out_valid,
  output logic [11:0]      year,
  output logic [3:0]       month,
  output logic [4:0]       day_of_month,
  output logic [4:0]       hour,
  output logic [5:0]       minute,
  output logic [5:0]       second
);

  // Working registers
  logic [31:0] num;     // input seconds, then days in the low bits
  logic [16:0] rem;     // seconds left over after each split
  logic [50:0] prod;    // registered reciprocal product
  logic [4:0]  hour_q;
  logic [5:0]  min_q;
  logic [11:0] yr;
  logic [1:0]  mod4;
  logic [6:0]  mod100;
  logic [8:0]  mod400;
  logic [3:0]  mon;

  logic [15:0] day_q;
  logic [31:0] day_base;
  logic [4:0]  hour_n;
  logic [16:0] hour_base;
  logic [5:0]  min_n;
  logic [16:0] min_base;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [15:0] days;

  // Quotients from the product register and the amounts to take off
  always_comb begin
    day_q     = prod[50:35];
    day_base  = 32'(day_q) * 32'(SECS_PER_DAY);
    hour_n    = prod[33:29];
    hour_base = 17'(hour_n) * SECS_PER_HOUR;
    min_n     = prod[23:18];
    min_base  = 17'(min_n) * SECS_PER_MIN;
  end

  // Year and month lengths from the leap-year residues
  always_comb begin
    days = num[15:0];
    leap = ((mod4 == 2'd0) && (mod100 != 7'd0)) || (mod400 == 9'd0);
    ylen = DAYS_IN_YEAR + {8'd0, leap};
    mlen = month_days(mon, leap);
    status.year_done  = days < {7'd0, ylen};
    status.month_done = (mon == LAST_MONTH) || (days < {11'd0, mlen});
    status.out_free   = !out_valid || !out_stall;
  end

  // Advance the working registers per command
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        num    <= utc_seconds;
        rem    <= 17'd0;
        hour_q <= 5'd0;
        min_q  <= 6'd0;
        yr     <= EPOCH_YEAR;
        mod4   <= EPOCH_MOD4;
        mod100 <= EPOCH_MOD100;
        mod400 <= EPOCH_MOD400;
        mon    <= 4'd1;
      end
      OP_DAY_MUL: begin
        prod <= 51'(num[31:7]) * 51'(DAY_RECIP);
      end
      OP_DAY_FIX: begin
        num <= {16'd0, day_q};
        rem <= 17'(num - day_base);
      end
      OP_HOUR_MUL: begin
        prod <= 51'(rem) * 51'(HOUR_RECIP);
      end
      OP_HOUR_FIX: begin
        hour_q <= hour_n;
        rem    <= rem - hour_base;
      end
      OP_MIN_MUL: begin
        prod <= 51'(rem[11:0]) * 51'(MIN_RECIP);
      end
      OP_MIN_FIX: begin
        min_q <= min_n;
        rem   <= rem - min_base;
      end
      OP_YEAR: begin
        if (!status.year_done) begin
          num[15:0] <= days - {7'd0, ylen};
          yr        <= yr + 12'd1;
          mod4      <= mod4 + 2'd1;
          mod100    <= (mod100 == 7'd99) ? 7'd0 : mod100 + 7'd1;
          mod400    <= (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;
        end
      end
      OP_MONTH: begin
        if (!status.month_done) begin
          num[15:0] <= days - {11'd0, mlen};
          mon       <= mon + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (cmd.op == OP_PUBLISH) begin
      year         <= yr;
      month        <= mon;
      day_of_month <= days[4:0] + 5'd1;
      hour         <= hour_q;
      minute       <= min_q;
      second       <= rem[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_PUBLISH) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/utc_ctrl.sv
// Controller: sequences the divider steps and the year and month loops.
`default_nettype none

module utc_ctrl
  import utc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_DAY_MUL;
        end
      end
      ST_DAY_MUL: begin
        cmd.op     = OP_DAY_MUL;
        state_next = ST_DAY_FIX;
      end
      ST_DAY_FIX: begin
        cmd.op     = OP_DAY_FIX;
        state_next = ST_HOUR_MUL;
      end
      ST_HOUR_MUL: begin
        cmd.op     = OP_HOUR_MUL;
        state_next = ST_HOUR_FIX;
      end
      ST_HOUR_FIX: begin
        cmd.op     = OP_HOUR_FIX;
        state_next = ST_MIN_MUL;
      end
      ST_MIN_MUL: begin
        cmd.op     = OP_MIN_MUL;
        state_next = ST_MIN_FIX;
      end
      ST_MIN_FIX: begin
        cmd.op     = OP_MIN_FIX;
        state_next = ST_YEAR;
      end
      ST_YEAR: begin
        if (status.year_done) begin
          state_next = ST_MONTH;
        end else begin
          cmd.op = OP_YEAR;
        end
      end
      ST_MONTH: begin
        if (status.month_done) begin
          state_next = ST_DONE;
        end else begin
          cmd.op = OP_MONTH;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.op     = OP_PUBLISH;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/utc_seconds_to_calendar.sv
// Top level: seconds since 1970 to Gregorian date and time of day.
//
//   channel | direction | handshake          | payload
//   input   | in        | in_valid/in_stall   | utc_seconds[31:0]
//   output  | out       | out_valid/out_stall | year, month, day_of_month, hour, minute, second
//
// A transaction's length is set mostly by the one-year-per-cycle year loop; the day, hour and
// minute splits each take a multiply step and then a fix step.
// Only one transaction is in flight; in_stall is high from acceptance until the result
// is moved into the output register, which then holds it while out_stall is high.
// Reset is synchronous and clears the controller and out_valid.
`default_nettype none

module utc_seconds_to_calendar
  import utc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] utc_seconds,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      year,
  output logic [3:0]       month,
  output logic [4:0]       day_of_month,
  output logic [4:0]       hour,
  output logic [5:0]       minute,
  output logic [5:0]       second
);

  dp_cmd_t    cmd;
  dp_status_t status;

  utc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  utc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .utc_seconds  (utc_seconds),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second)
  );

  // An accepted transaction keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after accepting a transaction");

  // Date fields in range whenever a result is shown
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month >= 4'd1) && (month <= 4'd12) && (day_of_month != 5'd0)
                  && (year >= 12'd1970) && (year <= 12'd2106))
    else $error("date field out of range");

  // Time-of-day fields in range whenever a result is shown
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59))
    else $error("time field out of range");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Testbench for utc_seconds_to_calendar: boundary and random epoch seconds checked against a date predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned SECS_DAY   = 86400;
  localparam int unsigned SECS_HOUR  = 3600;
  localparam int unsigned SECS_MIN   = 60;
  localparam int unsigned EPOCH      = 1970;
  localparam int unsigned LAST_YEAR  = 2106;
  localparam int unsigned DAYS_YEAR  = 365;
  localparam int unsigned FEBRUARY   = 2;
  localparam int unsigned DECEMBER   = 12;

  localparam int N_RANDOM      = 1700;
  localparam int DRAIN_AT      = 1200;
  localparam int HOLD_AT       = 400;
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 250;
  localparam int N_EDGES       = 24;

  // Boundary instants: epoch, unit rollovers, leap days, century years, top of range
  localparam logic [31:0] EDGE_SECS [N_EDGES] = '{
    32'd0,          32'd1,          32'd59,         32'd60,
    32'd3599,       32'd3600,       32'd86399,      32'd86400,
    32'd2678400,    32'd5097600,    32'd31535999,   32'd31536000,
    32'd68169600,   32'd94694399,   32'd946684800,  32'd951782400,
    32'd978307199,  32'd2147483647, 32'd4102444800, 32'd4107542399,
    32'd4107542400, 32'd4133980799, 32'd4294944000, 32'd4294967295
  };

  typedef struct {
    logic [31:0] secs;
    bit          drain;
  } stamp_item_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  typedef struct {
    logic [31:0] secs;
    calendar_t   cal;
  } dated_stamp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [31:0] utc_seconds = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  utc_seconds_to_calendar dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .utc_seconds  (utc_seconds),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second)
  );

  stamp_item_t  pending_q[$];
  dated_stamp_t dates_due_q[$];

  int unsigned errors = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned n_leap_days = 0;
  int unsigned yr_lo = LAST_YEAR;
  int unsigned yr_hi = 0;

  // Handshake outcomes of the last rising edge, for the falling-edge processes
  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  logic out_seen = 1'b0;

  function automatic bit leap_year(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
  endfunction

  function automatic int unsigned month_length(int unsigned m, int unsigned y);
    if (m == FEBRUARY) begin
      return leap_year(y) ? 29 : 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    return 31;
  endfunction

  // Split seconds into time of day, then consume whole years and months
  function automatic calendar_t to_calendar(logic [31:0] secs);
    calendar_t   c;
    int unsigned days;
    int unsigned tod;
    int unsigned yr;
    int unsigned mon;
    tod  = secs % SECS_DAY;
    days = secs / SECS_DAY;
    yr   = EPOCH;
    mon  = 1;
    while (days >= DAYS_YEAR + leap_year(yr)) begin
      days -= DAYS_YEAR + leap_year(yr);
      yr++;
    end
    while (mon < DECEMBER && days >= month_length(mon, yr)) begin
      days -= month_length(mon, yr);
      mon++;
    end
    c.year   = 12'(yr);
    c.month  = 4'(mon);
    c.mday   = 5'(days + 1);
    c.hour   = 5'(tod / SECS_HOUR);
    c.minute = 6'((tod % SECS_HOUR) / SECS_MIN);
    c.second = 6'(tod % SECS_MIN);
    return c;
  endfunction

  task automatic check_field(string what, logic [11:0] want_v, logic [11:0] got_v,
                             logic [31:0] secs);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s mismatch for seconds %0d: expected %0d, got %0d",
               $time, what, secs, want_v, got_v);
    end
  endtask

  // Clock
  initial begin
    forever #1 clk = ~clk;
  end

  // Driver: present queued timestamps with random gaps, hold until accepted; a drain item waits until no date is due
  int send_gap = 0;
  bit send_fast = 1'b0;
  logic send_next;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      send_next = in_valid && !in_fire;
      if (in_fire) begin
        if ($urandom_range(0, 39) == 0) send_fast = !send_fast;
        send_gap = send_fast ? 0 : $urandom_range(0, 6);
      end
      if (!send_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].drain && dates_due_q.size() > 0)) begin
          utc_seconds <= pending_q[0].secs;
          pending_q.pop_front();
          send_next = 1'b1;
        end
      end
      in_valid <= send_next;
    end
  end

  // Receiver: random stall per result, plus one long hold-off to back up the block
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  recv_fast = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_fire) begin
        if ($urandom_range(0, 39) == 0) recv_fast = !recv_fast;
        stall_left = recv_fast ? 0 : $urandom_range(0, 6);
      end
      if (!hold_done && n_checked >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0 && out_seen) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: predict on each accepted timestamp, check each accepted date
  calendar_t    got_cal;
  dated_stamp_t due;

  always @(posedge clk) begin
    if (rst) begin
      in_fire  <= 1'b0;
      out_fire <= 1'b0;
      out_seen <= 1'b0;
    end else begin
      in_fire  <= in_valid && !in_stall;
      out_fire <= out_valid && !out_stall;
      out_seen <= out_valid;
      if (in_valid && !in_stall) begin
        due.secs = utc_seconds;
        due.cal  = to_calendar(utc_seconds);
        dates_due_q.push_back(due);
        n_accepted++;
      end
      if (out_valid && !out_stall) begin
        got_cal = {year, month, day_of_month, hour, minute, second};
        if (dates_due_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected date, expected none, got %0d-%0d-%0d %0d:%0d:%0d",
                   $time, year, month, day_of_month, hour, minute, second);
        end else begin
          due = dates_due_q.pop_front();
          n_checked++;
          check_field("year",   12'(due.cal.year),   12'(got_cal.year),   due.secs);
          check_field("month",  12'(due.cal.month),  12'(got_cal.month),  due.secs);
          check_field("day",    12'(due.cal.mday),   12'(got_cal.mday),   due.secs);
          check_field("hour",   12'(due.cal.hour),   12'(got_cal.hour),   due.secs);
          check_field("minute", 12'(due.cal.minute), 12'(got_cal.minute), due.secs);
          check_field("second", 12'(due.cal.second), 12'(got_cal.second), due.secs);
          if (due.cal.year < yr_lo) yr_lo = due.cal.year;
          if (due.cal.year > yr_hi) yr_hi = due.cal.year;
          if (due.cal.month == FEBRUARY && due.cal.mday == 29) n_leap_days++;
        end
      end
    end
  end

  // Stimulus, reset and end of run
  stamp_item_t item;
  longint      s;
  int unsigned pick;
  int unsigned y;
  int unsigned m;
  int unsigned yy;
  int unsigned mm;

  initial begin
    for (int i = 0; i < N_EDGES; i++) begin
      item.secs  = EDGE_SECS[i];
      item.drain = 1'b0;
      pending_q.push_back(item);
    end
    for (int k = 0; k < N_RANDOM; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        s = $urandom;
      end else if (pick < 75) begin
        s = $urandom_range(0, 32'd400000000);
      end else begin
        // land within a day of a month start in a random year
        y = $urandom_range(EPOCH, LAST_YEAR);
        m = $urandom_range(1, DECEMBER);
        s = 0;
        for (yy = EPOCH; yy < y; yy++) s += (DAYS_YEAR + leap_year(yy)) * SECS_DAY;
        for (mm = 1; mm < m; mm++) s += month_length(mm, y) * SECS_DAY;
        s += longint'($urandom_range(0, 2 * SECS_DAY)) - SECS_DAY;
        if (s < 0) s = 0;
        if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
      end
      item.secs  = s[31:0];
      item.drain = (k == 0) || (k == DRAIN_AT);
      pending_q.push_back(item);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_q.size() > 0 || in_valid || dates_due_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Converted %0d timestamps, %0d dates checked, %0d mismatches",
             n_accepted, n_checked, errors);
    $display("Years %0d to %0d covered, %0d leap days hit, output held off %0d cycles once",
             yr_lo, yr_hi, n_leap_days, HOLD_CYCLES);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2500000;
    $display("Timeout with %0d dates still due", dates_due_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
